[rtl/core/thc_pkg.sv]
package thc_pkg;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_TEMP_ONE = 3'd0,
        REG_TEMP_TWO = 3'd1,
        REG_TEMP_THREE = 3'd2,
        REG_HUM_ONE = 3'd3,
        REG_HUM_TWO = 3'd4,
        REG_HUM_THREE = 3'd5,
        REG_HUM_FOUR_FIVE = 3'd6,
        REG_HUM_SIX = 3'd7
    } t_cfg_idx;

    localparam int CFG_DATA_W = 24;
    localparam int RAW_TEMP_W = 20;
    localparam int RAW_HUM_W = 16;
    localparam int TEMP_W = 16;
    localparam int HUM_W = 17;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 40;

    localparam logic signed [31:0] HUM_OFFSET_TFINE = 32'sd76800;
    localparam logic signed [31:0] HUM_CLAMP_MAX = 32'sd419430400;
    localparam logic signed [31:0] HUM_A_ROUND = 32'sd16384;
    localparam logic signed [31:0] HUM_E_OFFSET = 32'sd2097152;
    localparam logic signed [31:0] HUM_C_OFFSET = 32'sd32768;
    localparam logic signed [31:0] HUM_F_ROUND = 32'sd8192;
    localparam logic signed [31:0] TEMP_ROUND = 32'sd128;
    localparam logic signed [31:0] TEMP_MAX = 32'sd32767;
    localparam logic signed [31:0] TEMP_MIN = -32'sd32768;

endpackage

[rtl/core/temp_humidity_compensation_top.sv]
// Throughput: one item per cycle while m_axis_tready is high; twelve register stages,
// each at most one 32-bit multiply deep with a short add, shift or clamp around it,
// and a valid bit per stage.
// A stage stalls only when it is full and the stage after it cannot take its item.
// Reset (i_rst_n low, synchronous): empties every stage and clears all calibration words.
module temp_humidity_compensation_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  thc_pkg::t_cfg_idx                  i_cfg_idx,
    input  logic [thc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // input items
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [19:0] raw_temp, [35:20] raw_hum, [39:36] zero
    input  logic [thc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // result items
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [15:0] temp_centi, [32:16] hum_q10, [39:33] zero
    output logic [thc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import thc_pkg::*;

    localparam int NSTG = 12;

    // ------------------------------------------------------------------
    // Calibration words
    // ------------------------------------------------------------------
    logic        [15:0] r_t1;
    logic signed [15:0] r_t2;
    logic signed [15:0] r_t3;
    logic        [7:0]  r_h1;
    logic signed [15:0] r_h2;
    logic        [7:0]  r_h3;
    logic        [11:0] r_h4;
    logic        [11:0] r_h5;
    logic signed [7:0]  r_h6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
            r_t2 <= '0;
            r_t3 <= '0;
            r_h1 <= '0;
            r_h2 <= '0;
            r_h3 <= '0;
            r_h4 <= '0;
            r_h5 <= '0;
            r_h6 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TEMP_ONE:      r_t1 <= i_cfg_wdata[15:0];
                REG_TEMP_TWO:      r_t2 <= i_cfg_wdata[15:0];
                REG_TEMP_THREE:    r_t3 <= i_cfg_wdata[15:0];
                REG_HUM_ONE:       r_h1 <= i_cfg_wdata[7:0];
                REG_HUM_TWO:       r_h2 <= i_cfg_wdata[15:0];
                REG_HUM_THREE:     r_h3 <= i_cfg_wdata[7:0];
                REG_HUM_FOUR_FIVE: begin
                    r_h4 <= i_cfg_wdata[11:0];
                    r_h5 <= i_cfg_wdata[23:12];
                end
                REG_HUM_SIX:       r_h6 <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Calibration words widened to the 32-bit datapath (signed ones sign-extended)
    logic signed [31:0] w_t1, w_t2, w_t3, w_h1, w_h2, w_h3, w_h4, w_h5, w_h6;
    assign w_t1 = 32'(r_t1);
    assign w_t2 = 32'(r_t2);
    assign w_t3 = 32'(r_t3);
    assign w_h1 = 32'(r_h1);
    assign w_h2 = 32'(r_h2);
    assign w_h3 = 32'(r_h3);
    assign w_h4 = 32'(r_h4);
    assign w_h5 = 32'(r_h5);
    assign w_h6 = 32'(r_h6);

    // ------------------------------------------------------------------
    // Flow control: a stage advances when it is empty or its successor advances
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage registers
    // ------------------------------------------------------------------
    logic signed [31:0] r_s1_v1p, r_s1_dd;
    logic [RAW_HUM_W-1:0] r_s1_ah, r_s2_ah, r_s3_ah, r_s4_ah, r_s5_ah;
    logic signed [31:0] r_s2_v1, r_s2_ddv;
    logic signed [31:0] r_s3_tf;
    logic signed [31:0] r_s4_x;
    logic signed [31:0] r_s5_h5x, r_s5_bp, r_s5_cp;
    logic signed [31:0] r_s6_a, r_s6_b, r_s6_c;
    logic signed [31:0] r_s7_bc, r_s7_a;
    logic signed [31:0] r_s8_ep, r_s8_a;
    logic signed [31:0] r_s9_xf;
    logic signed [31:0] r_s10_ss, r_s10_xf;
    logic signed [31:0] r_s11_sh, r_s11_xf;
    logic [HUM_W-1:0]   r_s12_hum;
    logic [TEMP_W-1:0]  r_temp [4:NSTG];

    // ------------------------------------------------------------------
    // Next values of each stage
    // ------------------------------------------------------------------
    logic signed [31:0] n_at3, n_at4, n_dif1, n_d, n_s1_v1p, n_s1_dd;
    logic signed [31:0] n_s2_v1, n_dd12, n_s2_ddv;
    logic signed [31:0] n_s3_tf;
    logic signed [31:0] n_t, n_s4_x;
    logic [TEMP_W-1:0]  n_s4_temp;
    logic signed [31:0] n_s5_h5x, n_s5_bp, n_s5_cp;
    logic signed [31:0] n_a_sum, n_s6_a, n_s6_b, n_s6_c;
    logic signed [31:0] n_s7_bc;
    logic signed [31:0] n_e, n_s8_ep;
    logic signed [31:0] n_f_sum, n_f, n_s9_xf;
    logic signed [31:0] n_s, n_s10_ss;
    logic signed [31:0] n_ss7, n_s11_sh;
    logic signed [31:0] n_hx;
    logic [HUM_W-1:0]   n_s12_hum;

    always_comb begin
        // temperature: first term and squared offset
        n_at3    = 32'(s_axis_tdata[RAW_TEMP_W-1:3]);
        n_at4    = 32'(s_axis_tdata[RAW_TEMP_W-1:4]);
        n_dif1   = n_at3 - (w_t1 <<< 1);
        n_d      = n_at4 - w_t1;
        n_s1_v1p = n_dif1 * w_t2;
        n_s1_dd  = n_d * n_d;

        n_s2_v1  = r_s1_v1p >>> 11;
        n_dd12   = r_s1_dd >>> 12;
        n_s2_ddv = n_dd12 * w_t3;

        // fine temperature
        n_s3_tf  = r_s2_v1 + (r_s2_ddv >>> 14);

        // temperature in hundredths, saturated; humidity offset of fine temperature
        n_t = ((r_s3_tf <<< 2) + r_s3_tf + TEMP_ROUND) >>> 8;
        if (n_t < TEMP_MIN) begin
            n_s4_temp = TEMP_MIN[TEMP_W-1:0];
        end else if (n_t > TEMP_MAX) begin
            n_s4_temp = TEMP_MAX[TEMP_W-1:0];
        end else begin
            n_s4_temp = n_t[TEMP_W-1:0];
        end
        n_s4_x = r_s3_tf - HUM_OFFSET_TFINE;

        // humidity products on the offset value
        n_s5_h5x = w_h5 * r_s4_x;
        n_s5_bp  = r_s4_x * w_h6;
        n_s5_cp  = r_s4_x * w_h3;

        n_a_sum = (32'(r_s5_ah) <<< 14) - (w_h4 <<< 20) - r_s5_h5x + HUM_A_ROUND;
        n_s6_a  = n_a_sum >>> 15;
        n_s6_b  = r_s5_bp >>> 10;
        n_s6_c  = (r_s5_cp >>> 11) + HUM_C_OFFSET;

        n_s7_bc = r_s6_b * r_s6_c;

        n_e     = (r_s7_bc >>> 10) + HUM_E_OFFSET;
        n_s8_ep = n_e * w_h2;

        n_f_sum = r_s8_ep + HUM_F_ROUND;
        n_f     = n_f_sum >>> 14;
        n_s9_xf = r_s8_a * n_f;

        n_s      = r_s9_xf >>> 15;
        n_s10_ss = n_s * n_s;

        n_ss7    = r_s10_ss >>> 7;
        n_s11_sh = n_ss7 * w_h1;

        // final correction and clamp to 0..100 %RH in Q22.10 << 12
        n_hx = r_s11_xf - (r_s11_sh >>> 4);
        if (n_hx < 0) begin
            n_hx = '0;
        end else if (n_hx > HUM_CLAMP_MAX) begin
            n_hx = HUM_CLAMP_MAX;
        end
        n_s12_hum = n_hx[HUM_W+11:12];
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s1_v1p <= n_s1_v1p;
            r_s1_dd  <= n_s1_dd;
            r_s1_ah  <= s_axis_tdata[RAW_TEMP_W+RAW_HUM_W-1:RAW_TEMP_W];
        end
        if (en[1]) begin
            r_s2_v1  <= n_s2_v1;
            r_s2_ddv <= n_s2_ddv;
            r_s2_ah  <= r_s1_ah;
        end
        if (en[2]) begin
            r_s3_tf <= n_s3_tf;
            r_s3_ah <= r_s2_ah;
        end
        if (en[3]) begin
            r_s4_x    <= n_s4_x;
            r_s4_ah   <= r_s3_ah;
            r_temp[4] <= n_s4_temp;
        end
        if (en[4]) begin
            r_s5_h5x <= n_s5_h5x;
            r_s5_bp  <= n_s5_bp;
            r_s5_cp  <= n_s5_cp;
            r_s5_ah  <= r_s4_ah;
        end
        if (en[5]) begin
            r_s6_a <= n_s6_a;
            r_s6_b <= n_s6_b;
            r_s6_c <= n_s6_c;
        end
        if (en[6]) begin
            r_s7_bc <= n_s7_bc;
            r_s7_a  <= r_s6_a;
        end
        if (en[7]) begin
            r_s8_ep <= n_s8_ep;
            r_s8_a  <= r_s7_a;
        end
        if (en[8]) begin
            r_s9_xf <= n_s9_xf;
        end
        if (en[9]) begin
            r_s10_ss <= n_s10_ss;
            r_s10_xf <= r_s9_xf;
        end
        if (en[10]) begin
            r_s11_sh <= n_s11_sh;
            r_s11_xf <= r_s10_xf;
        end
        if (en[11]) begin
            r_s12_hum <= n_s12_hum;
        end
        // carry the finished temperature down to the output stage
        for (int k = 5; k <= NSTG; k++) begin
            if (en[k-1]) begin
                r_temp[k] <= r_temp[k-1];
            end
        end
    end

    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tdata  = {(OUT_DATA_W - HUM_W - TEMP_W)'(0), r_s12_hum, r_temp[NSTG]};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // an empty pipeline always takes an item
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld == '0) |-> s_axis_tready)
        else $error("empty pipeline refused an item");

    // an accepted item occupies the first stage on the next edge
    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_vld[0])
        else $error("accepted item lost at the first stage");

    // a result on offer never exceeds 100 %RH
    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[TEMP_W+HUM_W-1:TEMP_W] <= 17'd102400))
        else $error("humidity result above full scale");

    // a stalled output stage keeps its item
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("stalled result dropped");

endmodule
